// ----- design/bfaq_pkg.sv -----
`default_nettype none
package bfaq_pkg;
  localparam int unsigned BIT_STORE_SIZE_DEF = 16384;
  localparam logic [63:0] FNV_MUL   = 64'h0000_0100_0000_01b3;
  localparam logic [63:0] FNV_START = 64'hcbf2_9ce4_8422_2325;
  localparam logic [63:0] DJB_START = 64'd5381;
  localparam int unsigned DJB_SHIFT = 5;
  localparam int unsigned CFG_W = 15;

  localparam logic [1:0] REG_BIT_COUNT  = 2'd0;
  localparam logic [1:0] REG_HASH_COUNT = 2'd1;
  localparam logic [1:0] REG_HASH_ORDER = 2'd2;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [CFG_W-1:0] divisor;
  } div_req_t;
endpackage
`default_nettype wire

// ----- design/bfaq_mod.sv -----
`default_nettype none
// Restoring remainder, one quotient bit per cycle, over the 64-bit dividend.
module bfaq_mod (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire bfaq_pkg::div_req_t          req,
  output logic                             done,
  output logic [bfaq_pkg::CFG_W-1:0]       rem
);
  logic [63:0] dvd;
  logic [bfaq_pkg::CFG_W:0] r;
  logic [bfaq_pkg::CFG_W-1:0] dvs;
  logic [6:0] cnt;
  logic busy;
  logic [bfaq_pkg::CFG_W+1:0] trial;

  always_comb begin
    trial = {r, dvd[63]} - {2'b00, dvs};
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      dvd <= req.dividend;
      dvs <= req.divisor;
      r <= '0;
      cnt <= 7'd64;
    end else if (busy) begin
      dvd <= {dvd[62:0], 1'b0};
      if (!trial[bfaq_pkg::CFG_W+1]) r <= trial[bfaq_pkg::CFG_W:0];
      else r <= {r[bfaq_pkg::CFG_W-1:0], dvd[63]};
      cnt <= cnt - 7'd1;
      if (cnt == 7'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign rem = r[bfaq_pkg::CFG_W-1:0];
endmodule
`default_nettype wire

// ----- design/bloom_filter_add_query_top.sv -----
`default_nettype none
// Bloom filter over byte-stream keys. An item with a byte and no key end passes through
// S_MUL. The FNV multiply by its constant is split into two registered partial sums,
// which S_MUL or S_SUM adds. An item with neither byte nor key end leaves the block idle.
// A key end runs, for each hash, S_DIV, which starts the modulo unit, S_WAIT on its
// bit-serial remainder, then S_READ, a registered read of the bit store, S_MOD, the
// write-back, and S_NEXT, a step. S_OUT then posts the result; a final item that carries
// a byte first passes through S_SUM. After reset the bit store is cleared one word a
// cycle, with busy high. Results appear for one cycle on done with done_kind and
// maybe_present; the receiver cannot stall.
module bloom_filter_add_query_top #(
  parameter int unsigned BIT_STORE_SIZE = bfaq_pkg::BIT_STORE_SIZE_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        kind,
  input  wire logic [7:0]  key_byte,
  input  wire logic        byte_valid,
  input  wire logic        key_last,
  output logic             done,
  output logic             done_kind,
  output logic             maybe_present,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  localparam int unsigned WORDS = (BIT_STORE_SIZE + 31) / 32;
  localparam int unsigned AW = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned CW = bfaq_pkg::CFG_W;

  localparam logic [1:0] REG_BIT_COUNT_C  = bfaq_pkg::REG_BIT_COUNT;
  localparam logic [1:0] REG_HASH_COUNT_C = bfaq_pkg::REG_HASH_COUNT;
  localparam logic [1:0] REG_HASH_ORDER_C = bfaq_pkg::REG_HASH_ORDER;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MUL, S_SUM, S_DIV, S_WAIT, S_READ, S_MOD, S_NEXT, S_OUT
  } state_t;
  state_t state;

  logic [CW-1:0] bit_count;
  logic [1:0] hash_count;
  logic hash_order;

  logic [31:0] mem [WORDS];
  logic [31:0] rd;
  logic [AW-1:0] waddr, raddr;
  logic [31:0] wdata;
  logic we;

  logic [63:0] fnv, djb, xr;
  logic [63:0] pp0, pp1;
  logic kind_r, all, sel;
  logic [AW-1:0] clr;
  logic [CW-1:0] idx;
  logic [4:0] bitpos;
  bfaq_pkg::div_req_t dreq;
  logic ddone;
  logic [CW-1:0] rem;
  logic [CW-1:0] dvs;
  logic [63:0] h, mag;
  logic [1:0] nh;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd <= mem[raddr];
  end

  bfaq_mod u_mod (.clk(clk), .rst(rst), .req(dreq), .done(ddone), .rem(rem));

  always_comb begin
    if (bit_count == '0) dvs = CW'(1);
    else if ({17'd0, bit_count} > BIT_STORE_SIZE) dvs = CW'(BIT_STORE_SIZE);
    else dvs = bit_count;
    nh = (hash_count inside {2'd2, 2'd3}) ? 2'd2 : 2'd1;
    h = ((hash_order ^ sel) == 1'b0) ? fnv : djb;
    mag = h[63] ? (~h + 64'd1) : h;
    dreq.start = (state == S_DIV);
    dreq.dividend = mag;
    dreq.divisor = dvs;
    idx = rem;
    bitpos = idx[4:0];
    raddr = AW'(idx >> 5);
  end

  assign xr = fnv ^ {56'd0, key_byte};
  assign we = (state == S_CLEAR) || (state == S_MOD && !kind_r);
  assign waddr = (state == S_CLEAR) ? clr : raddr;
  assign wdata = (state == S_CLEAR) ? 32'd0 : (rd | (32'd1 << bitpos));
  assign busy = (state != S_IDLE);
  assign pready = 1'b1;

  always_comb begin
    case (paddr[3:2])
      REG_BIT_COUNT_C:  prdata = {{(32-CW){1'b0}}, bit_count};
      REG_HASH_COUNT_C: prdata = {30'd0, hash_count};
      REG_HASH_ORDER_C: prdata = {31'd0, hash_order};
      default:          prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_count <= CW'(16384);
      hash_count <= 2'd2;
      hash_order <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_BIT_COUNT_C:  bit_count <= pwdata[CW-1:0];
        REG_HASH_COUNT_C: hash_count <= pwdata[1:0];
        REG_HASH_ORDER_C: hash_order <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      fnv <= bfaq_pkg::FNV_START;
      djb <= bfaq_pkg::DJB_START;
    end else begin
      case (state)
        S_CLEAR: begin
          clr <= clr + AW'(1);
          if (clr == AW'(WORDS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            kind_r <= kind;
            sel <= 1'b0;
            all <= 1'b1;
            if (byte_valid) begin
              // 0x100000001b3 = 2^40 + 2^8 + 2^7 + 2^5 + 2^4 + 2^1 + 1
              pp0 <= xr + {xr[62:0], 1'b0} + {xr[59:0], 4'd0};
              pp1 <= {xr[58:0], 5'd0} + {xr[56:0], 7'd0} + {xr[55:0], 8'd0}
                     + {xr[23:0], 40'd0};
              djb <= (djb << bfaq_pkg::DJB_SHIFT) + djb + {56'd0, key_byte};
              state <= key_last ? S_SUM : S_MUL;
            end else if (key_last) begin
              state <= S_DIV;
            end
          end
        end
        S_MUL, S_SUM: begin
          fnv <= pp0 + pp1;
          state <= (state == S_SUM) ? S_DIV : S_IDLE;
        end
        S_DIV: state <= S_WAIT;
        S_WAIT: if (ddone) state <= S_READ;
        S_READ: state <= S_MOD;
        S_MOD: begin
          if (!rd[bitpos]) all <= 1'b0;
          state <= S_NEXT;
        end
        S_NEXT: begin
          if (!sel && nh == 2'd2) begin
            sel <= 1'b1;
            state <= S_DIV;
          end else begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          done <= 1'b1;
          done_kind <= kind_r;
          maybe_present <= kind_r ? all : 1'b1;
          fnv <= bfaq_pkg::FNV_START;
          djb <= bfaq_pkg::DJB_START;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- design/bfaq_checker.sv -----
`default_nettype none
module bfaq_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic key_last,
  input wire logic done,
  input wire logic done_kind,
  input wire logic maybe_present,
  input wire logic pready
);
  a_add_yes: assert property (@(posedge clk) disable iff (rst)
    done && !done_kind |-> maybe_present) else $error("add result not 1");
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("result while idle");
  a_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("two results back to back");
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && key_last |=> busy) else $error("key end item not taken");
  a_ready: assert property (@(posedge clk) pready) else $error("pready low");
endmodule

bind bloom_filter_add_query_top bfaq_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .key_last(key_last), .done(done),
  .done_kind(done_kind), .maybe_present(maybe_present), .pready(pready)
);
`default_nettype wire
